/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the triangle box clipper.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with an active-low reset.
`define TBC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Assertion on the standard clk_i / rst_ni pair.
`define TBC_ASSERT_STD(lbl, prop, msg) \
  `TBC_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

/* design/tbc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbc_pkg
// Shared types and constants of the triangle box clipper.
// ----------------------------------------------------------------------------
package tbc_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned MAG_W   = 33;
  localparam int unsigned PROD_W  = 66;
  localparam int unsigned QUO_W   = 34;
  localparam int unsigned TOL_W   = 16;
  localparam int unsigned CFG_W   = 3;

  localparam logic [CFG_W-1:0] CFG_BOX_LOW_X  = 3'd0;
  localparam logic [CFG_W-1:0] CFG_BOX_LOW_Y  = 3'd1;
  localparam logic [CFG_W-1:0] CFG_BOX_LOW_Z  = 3'd2;
  localparam logic [CFG_W-1:0] CFG_BOX_HIGH_X = 3'd3;
  localparam logic [CFG_W-1:0] CFG_BOX_HIGH_Y = 3'd4;
  localparam logic [CFG_W-1:0] CFG_BOX_HIGH_Z = 3'd5;
  localparam logic [CFG_W-1:0] CFG_TOLERANCE  = 3'd6;

  localparam logic signed [COORD_W-1:0] BOX_LOW_RST  = 32'sd0;
  localparam logic signed [COORD_W-1:0] BOX_HIGH_RST = 32'sd65536;
  localparam logic [TOL_W-1:0]          TOL_RST      = 16'd1;

  localparam logic [1:0] STATUS_VALID = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_ERROR = 2'd2;

  localparam logic [2:0] PLANE_COUNT = 3'd6;

  typedef logic [2:0][COORD_W-1:0] vtx_t;

  typedef struct packed {
    logic load_vtx;
    logic plane_next;
    logic rd_last;
    logic rd_idx;
    logic ld_a;
    logic ld_b;
    logic push_a;
    logic push_b;
    logic push_pt;
    logic adv;
    logic pass_end;
    logic k_clr;
    logic md_start;
    logic pt_store;
    logic out_clr;
    logic out_next;
    logic emit_vtx;
    logic emit_empty;
    logic emit_err;
  } cmd_t;

  typedef struct packed {
    logic loaded_two;
    logic plane_done;
    logic apply;
    logic need_int;
    logic push_a_req;
    logic push_b_req;
    logic i_last;
    logic cnt_zero;
    logic int_ok;
    logic pt_on;
    logic md_done;
    logic k_last;
  } sts_t;

endpackage
`default_nettype wire

/* design/triangle_box_clipper.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_box_clipper
// Clips a triangle against a configurable axis-aligned box, one plane at a time.
// ----------------------------------------------------------------------------
// The first two vertices of a triangle are taken on start with busy low.
// The third vertex starts the clip: applied planes walk every polygon edge, skipped planes
// do not, and each intersection runs on the shared bit-serial multiply-divide unit (three
// runs and two checks).
// Results leave one word per read and emit, never stalled; a new triangle is taken once busy drops.
// Reset clears the sequencer and loads the box to 0..1.0 with a tolerance of 1 LSB.
module triangle_box_clipper #(
  parameter int unsigned MAX_POLY_VERTS = 9,
  parameter int unsigned COORD_BITS     = 32
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic signed [tbc_pkg::COORD_W-1:0] vert_x_i,
  input  wire logic signed [tbc_pkg::COORD_W-1:0] vert_y_i,
  input  wire logic signed [tbc_pkg::COORD_W-1:0] vert_z_i,
  output logic                                    out_valid_o,
  output logic signed [tbc_pkg::COORD_W-1:0]      out_x_o,
  output logic signed [tbc_pkg::COORD_W-1:0]      out_y_o,
  output logic signed [tbc_pkg::COORD_W-1:0]      out_z_o,
  output logic                                    last_vertex_o,
  output logic [1:0]                              clip_status_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [tbc_pkg::CFG_W-1:0]          cfg_addr_i,
  input  wire logic [tbc_pkg::COORD_W-1:0]        cfg_data_i
);
  import tbc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  tbc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  tbc_datapath #(
    .MAX_POLY_VERTS (MAX_POLY_VERTS),
    .COORD_BITS     (COORD_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .vert_x_i      (vert_x_i),
    .vert_y_i      (vert_y_i),
    .vert_z_i      (vert_z_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_x_o       (out_x_o),
    .out_y_o       (out_y_o),
    .out_z_o       (out_z_o),
    .last_vertex_o (last_vertex_o),
    .clip_status_o (clip_status_o)
  );

endmodule
`default_nettype wire

/* design/tbc_muldiv.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbc_muldiv
// Bit-serial unit computing round(a * b / c) on unsigned magnitudes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module tbc_muldiv (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [tbc_pkg::MAG_W-1:0]   a_i,
  input  wire logic [tbc_pkg::MAG_W-1:0]   b_i,
  input  wire logic [tbc_pkg::MAG_W-1:0]   c_i,
  output logic                             done_o,
  output logic [tbc_pkg::QUO_W-1:0]        q_o
);
  import tbc_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  logic [1:0]        phase_q, phase_d;
  logic [6:0]        cnt_q, cnt_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [PROD_W-1:0] mcand_q, mcand_d;
  logic [MAG_W-1:0]  mplier_q, mplier_d;
  logic [MAG_W-1:0]  rem_q, rem_d;
  logic [MAG_W-1:0]  div_q, div_d;
  logic [MAG_W:0]    rem_t;
  logic              ge;
  logic              rnd;

  assign rem_t = {rem_q, prod_q[PROD_W-1]};
  assign ge    = rem_t >= {1'b0, div_q};
  assign rnd   = {rem_q, 1'b0} >= {1'b0, div_q};
  assign q_o   = prod_q[QUO_W-1:0] + QUO_W'(rnd);
  assign done_o = phase_q == PH_DONE;

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    prod_d   = prod_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    rem_d    = rem_q;
    div_d    = div_q;
    unique case (phase_q)
      PH_IDLE: begin
        if (start_i) begin
          mcand_d  = PROD_W'(a_i);
          mplier_d = b_i;
          div_d    = c_i;
          prod_d   = '0;
          cnt_d    = '0;
          phase_d  = PH_MUL;
        end
      end
      PH_MUL: begin
        if (mplier_q[0]) begin
          prod_d = prod_q + mcand_q;
        end
        mcand_d  = {mcand_q[PROD_W-2:0], 1'b0};
        mplier_d = {1'b0, mplier_q[MAG_W-1:1]};
        cnt_d    = cnt_q + 7'd1;
        if (cnt_q == 7'(MAG_W - 1)) begin
          cnt_d   = '0;
          rem_d   = '0;
          phase_d = PH_DIV;
        end
      end
      PH_DIV: begin
        rem_d  = ge ? MAG_W'(rem_t - {1'b0, div_q}) : MAG_W'(rem_t);
        prod_d = {prod_q[PROD_W-2:0], ge};
        cnt_d  = cnt_q + 7'd1;
        if (cnt_q == 7'(PROD_W - 1)) begin
          phase_d = PH_DONE;
        end
      end
      PH_DONE: begin
        phase_d = PH_IDLE;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    rem_q    <= rem_d;
    div_q    <= div_d;
  end

  `TBC_ASSERT_STD(a_start_idle, start_i |-> (phase_q == PH_IDLE), "muldiv started while busy")
  `TBC_ASSERT_STD(a_done_after_div, done_o |-> ($past(phase_q) == PH_DIV), "done without divide")
  `TBC_ASSERT_STD(a_done_pulse, done_o |=> !done_o, "done longer than one cycle")

endmodule
`default_nettype wire

/* design/tbc_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbc_datapath
// Box registers, polygon stores, plane classification and intersection math.
// ----------------------------------------------------------------------------
module tbc_datapath #(
  parameter int unsigned MAX_POLY_VERTS = 9,
  parameter int unsigned COORD_BITS     = 32
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [tbc_pkg::CFG_W-1:0]          cfg_addr_i,
  input  wire logic [tbc_pkg::COORD_W-1:0]        cfg_data_i,
  input  wire logic signed [tbc_pkg::COORD_W-1:0] vert_x_i,
  input  wire logic signed [tbc_pkg::COORD_W-1:0] vert_y_i,
  input  wire logic signed [tbc_pkg::COORD_W-1:0] vert_z_i,
  input  wire tbc_pkg::cmd_t                      cmd_i,
  output tbc_pkg::sts_t                           sts_o,
  output logic                                    out_valid_o,
  output logic signed [tbc_pkg::COORD_W-1:0]      out_x_o,
  output logic signed [tbc_pkg::COORD_W-1:0]      out_y_o,
  output logic signed [tbc_pkg::COORD_W-1:0]      out_z_o,
  output logic                                    last_vertex_o,
  output logic [1:0]                              clip_status_o
);
  import tbc_pkg::*;

  localparam int unsigned IW = $clog2(MAX_POLY_VERTS);
  localparam int unsigned NW = $clog2(MAX_POLY_VERTS + 1);
  localparam int unsigned CW = (COORD_BITS > 32) ? 32 : COORD_BITS;
  localparam int unsigned SH = 32 - CW;

  typedef enum logic [1:0] {SIDE_FRONT, SIDE_ON, SIDE_BEHIND} side_e;

  function automatic side_e classify(input logic signed [COORD_W-1:0] p,
                                     input logic signed [COORD_W-1:0] pos,
                                     input logic up,
                                     input logic [TOL_W-1:0] tol);
    logic signed [COORD_W+1:0] diff;
    logic signed [COORD_W+1:0] tl;
    begin
      diff = up ? ((COORD_W+2)'(p) - (COORD_W+2)'(pos))
                : ((COORD_W+2)'(pos) - (COORD_W+2)'(p));
      tl = $signed({{(COORD_W+2-TOL_W){1'b0}}, tol});
      if (diff > tl) begin
        classify = SIDE_FRONT;
      end else if (diff < -tl) begin
        classify = SIDE_BEHIND;
      end else begin
        classify = SIDE_ON;
      end
    end
  endfunction

  function automatic logic [MAG_W-1:0] mag(input logic signed [MAG_W-1:0] v);
    mag = v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
  endfunction

  function automatic logic signed [COORD_W-1:0] sext_in(input logic [COORD_W-1:0] v);
    logic signed [COORD_W-1:0] t;
    begin
      t = $signed(v << SH);
      sext_in = t >>> SH;
    end
  endfunction

  logic signed [COORD_W-1:0] box_lo_q [3];
  logic signed [COORD_W-1:0] box_hi_q [3];
  logic [TOL_W-1:0]          tol_q;

  vtx_t mem_q [2][MAX_POLY_VERTS];
  vtx_t rdata_q;
  vtx_t a_q, b_q, pt_q;
  logic signed [COORD_W-1:0] mn_q [3];
  logic signed [COORD_W-1:0] mx_q [3];

  logic          bank_q;
  logic [1:0]    loaded_q;
  logic [2:0]    plane_q;
  logic [NW-1:0] n_q, cnt_q;
  logic [IW-1:0] i_q;
  logic [1:0]    k_q;

  logic                      out_valid_q, out_last_q;
  logic [1:0]                out_status_q;
  logic signed [COORD_W-1:0] out_x_q, out_y_q, out_z_q;

  logic [1:0]                axis;
  logic                      upper;
  logic signed [COORD_W-1:0] pos, mn_ax, mx_ax, a_ax, b_ax, pt_ax, a_k, b_k;
  side_e                     a_side, b_side;
  logic signed [MAG_W-1:0]   num, den, dk;
  logic [MAG_W-1:0]          num_m, den_m, dk_m;
  logic                      neg;
  logic [QUO_W-1:0]          md_q;
  logic                      md_done;
  logic signed [QUO_W:0]     pt_wide;
  vtx_t                      vin;
  logic                      wr_en, wr_bank, rd_en, room;
  logic [IW-1:0]             wr_addr, rd_addr;
  vtx_t                      wr_data;
  logic [NW-1:0]             n_m1;

  assign axis  = plane_q[2:1];
  assign upper = plane_q[0];

  always_comb begin
    case (axis)
      2'd0: begin
        pos = upper ? box_hi_q[0] : box_lo_q[0];
        mn_ax = mn_q[0]; mx_ax = mx_q[0];
        a_ax = $signed(a_q[0]); b_ax = $signed(b_q[0]); pt_ax = $signed(pt_q[0]);
      end
      2'd1: begin
        pos = upper ? box_hi_q[1] : box_lo_q[1];
        mn_ax = mn_q[1]; mx_ax = mx_q[1];
        a_ax = $signed(a_q[1]); b_ax = $signed(b_q[1]); pt_ax = $signed(pt_q[1]);
      end
      2'd2: begin
        pos = upper ? box_hi_q[2] : box_lo_q[2];
        mn_ax = mn_q[2]; mx_ax = mx_q[2];
        a_ax = $signed(a_q[2]); b_ax = $signed(b_q[2]); pt_ax = $signed(pt_q[2]);
      end
      default: begin
        pos = '0; mn_ax = '0; mx_ax = '0; a_ax = '0; b_ax = '0; pt_ax = '0;
      end
    endcase
    case (k_q)
      2'd0: begin a_k = $signed(a_q[0]); b_k = $signed(b_q[0]); end
      2'd1: begin a_k = $signed(a_q[1]); b_k = $signed(b_q[1]); end
      2'd2: begin a_k = $signed(a_q[2]); b_k = $signed(b_q[2]); end
      default: begin a_k = '0; b_k = '0; end
    endcase
  end

  assign a_side = classify(a_ax, pos, upper, tol_q);
  assign b_side = classify(b_ax, pos, upper, tol_q);

  assign num   = MAG_W'(pos) - MAG_W'(a_ax);
  assign den   = MAG_W'(b_ax) - MAG_W'(a_ax);
  assign dk    = MAG_W'(b_k) - MAG_W'(a_k);
  assign num_m = mag(num);
  assign den_m = mag(den);
  assign dk_m  = mag(dk);
  assign neg   = (num[MAG_W-1] != dk[MAG_W-1]) && (num != '0) && (dk != '0);

  tbc_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.md_start),
    .a_i     (num_m),
    .b_i     (dk_m),
    .c_i     (den_m),
    .done_o  (md_done),
    .q_o     (md_q)
  );

  assign pt_wide = neg ? ((QUO_W+1)'(a_k) - $signed({1'b0, md_q}))
                       : ((QUO_W+1)'(a_k) + $signed({1'b0, md_q}));

  assign vin[0] = sext_in(vert_x_i);
  assign vin[1] = sext_in(vert_y_i);
  assign vin[2] = sext_in(vert_z_i);

  assign n_m1 = n_q - NW'(1);
  assign room = cnt_q < NW'(MAX_POLY_VERTS);

  always_comb begin
    wr_en   = 1'b0;
    wr_bank = ~bank_q;
    wr_addr = cnt_q[IW-1:0];
    wr_data = a_q;
    if (cmd_i.load_vtx) begin
      wr_en   = 1'b1;
      wr_bank = 1'b0;
      wr_addr = IW'(loaded_q);
      wr_data = vin;
    end else if (cmd_i.push_a || cmd_i.push_b || cmd_i.push_pt) begin
      wr_en   = room;
      wr_data = cmd_i.push_b ? b_q : (cmd_i.push_pt ? pt_q : a_q);
    end
    rd_en   = cmd_i.rd_last || cmd_i.rd_idx;
    rd_addr = cmd_i.rd_last ? n_m1[IW-1:0] : i_q;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_bank][wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[bank_q][rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < 3; j++) begin
        box_lo_q[j] <= BOX_LOW_RST;
        box_hi_q[j] <= BOX_HIGH_RST;
      end
      tol_q       <= TOL_RST;
      bank_q      <= 1'b0;
      loaded_q    <= '0;
      plane_q     <= '0;
      n_q         <= '0;
      cnt_q       <= '0;
      i_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_BOX_LOW_X:  box_lo_q[0] <= $signed(cfg_data_i);
          CFG_BOX_LOW_Y:  box_lo_q[1] <= $signed(cfg_data_i);
          CFG_BOX_LOW_Z:  box_lo_q[2] <= $signed(cfg_data_i);
          CFG_BOX_HIGH_X: box_hi_q[0] <= $signed(cfg_data_i);
          CFG_BOX_HIGH_Y: box_hi_q[1] <= $signed(cfg_data_i);
          CFG_BOX_HIGH_Z: box_hi_q[2] <= $signed(cfg_data_i);
          CFG_TOLERANCE:  tol_q       <= cfg_data_i[TOL_W-1:0];
          default: ;
        endcase
      end
      out_valid_q <= cmd_i.emit_vtx || cmd_i.emit_empty || cmd_i.emit_err;
      if (cmd_i.load_vtx) begin
        if (loaded_q == 2'd2) begin
          loaded_q <= '0;
          plane_q  <= '0;
          n_q      <= NW'(3);
          bank_q   <= 1'b0;
        end else begin
          loaded_q <= loaded_q + 2'd1;
        end
      end
      if (cmd_i.plane_next || cmd_i.pass_end) begin
        plane_q <= plane_q + 3'd1;
      end
      if (cmd_i.pass_end) begin
        n_q    <= cnt_q;
        bank_q <= ~bank_q;
      end
      if (cmd_i.ld_a || cmd_i.out_clr) begin
        i_q <= '0;
      end
      if (cmd_i.ld_a) begin
        cnt_q <= '0;
      end
      if ((cmd_i.push_a || cmd_i.push_b || cmd_i.push_pt) && room) begin
        cnt_q <= cnt_q + NW'(1);
      end
      if (cmd_i.adv || cmd_i.out_next) begin
        i_q <= i_q + IW'(1);
      end
      if (cmd_i.k_clr) begin
        k_q <= '0;
      end else if (cmd_i.pt_store) begin
        k_q <= k_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_vtx) begin
      for (int j = 0; j < 3; j++) begin
        if (loaded_q == 2'd0 || $signed(vin[j]) < mn_q[j]) begin
          mn_q[j] <= $signed(vin[j]);
        end
        if (loaded_q == 2'd0 || $signed(vin[j]) > mx_q[j]) begin
          mx_q[j] <= $signed(vin[j]);
        end
      end
    end
    if (cmd_i.ld_a) begin
      a_q <= rdata_q;
    end else if (cmd_i.adv) begin
      a_q <= b_q;
    end
    if (cmd_i.ld_b) begin
      b_q <= rdata_q;
    end
    if (cmd_i.pt_store) begin
      pt_q[k_q] <= pt_wide[COORD_W-1:0];
    end
    if (cmd_i.emit_vtx) begin
      out_x_q      <= $signed(rdata_q[0]);
      out_y_q      <= $signed(rdata_q[1]);
      out_z_q      <= $signed(rdata_q[2]);
      out_last_q   <= sts_o.i_last;
      out_status_q <= STATUS_VALID;
    end else if (cmd_i.emit_empty || cmd_i.emit_err) begin
      out_x_q      <= '0;
      out_y_q      <= '0;
      out_z_q      <= '0;
      out_last_q   <= 1'b1;
      out_status_q <= cmd_i.emit_err ? STATUS_ERROR : STATUS_EMPTY;
    end
  end

  always_comb begin
    sts_o.loaded_two = loaded_q == 2'd2;
    sts_o.plane_done = plane_q >= PLANE_COUNT;
    sts_o.apply      = upper ? (mn_ax < pos) : (mx_ax > pos);
    sts_o.need_int   = (b_side == SIDE_FRONT && a_side == SIDE_BEHIND)
                    || (b_side == SIDE_BEHIND && a_side == SIDE_FRONT);
    sts_o.push_a_req = b_side == SIDE_BEHIND && a_side == SIDE_ON;
    sts_o.push_b_req = (b_side == SIDE_ON && a_side == SIDE_BEHIND)
                    || b_side == SIDE_BEHIND;
    sts_o.i_last     = NW'(i_q) == n_m1;
    sts_o.cnt_zero   = cnt_q == '0;
    sts_o.int_ok     = (den != '0)
                    && !((num != '0) && (num[MAG_W-1] != den[MAG_W-1]))
                    && (num_m <= den_m);
    sts_o.pt_on      = classify(pt_ax, pos, upper, tol_q) == SIDE_ON;
    sts_o.md_done    = md_done;
    sts_o.k_last     = k_q == 2'd2;
  end

  assign out_valid_o   = out_valid_q;
  assign out_x_o       = out_x_q;
  assign out_y_o       = out_y_q;
  assign out_z_o       = out_z_q;
  assign last_vertex_o = out_last_q;
  assign clip_status_o = out_status_q;

endmodule
`default_nettype wire

/* design/tbc_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbc_ctrl
// Sequencer that walks the clip planes, polygon edges and result words.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module tbc_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire tbc_pkg::sts_t sts_i,
  output tbc_pkg::cmd_t      cmd_o,
  output logic               busy_o
);
  import tbc_pkg::*;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_PLANE    = 5'd1;
  localparam logic [4:0] S_LD_A     = 5'd2;
  localparam logic [4:0] S_RD_B     = 5'd3;
  localparam logic [4:0] S_LD_B     = 5'd4;
  localparam logic [4:0] S_DECIDE   = 5'd5;
  localparam logic [4:0] S_PUSH_B   = 5'd6;
  localparam logic [4:0] S_ADV      = 5'd7;
  localparam logic [4:0] S_PASS_END = 5'd8;
  localparam logic [4:0] S_EMPTY    = 5'd9;
  localparam logic [4:0] S_ERR      = 5'd10;
  localparam logic [4:0] S_INT_CHK  = 5'd11;
  localparam logic [4:0] S_INT_GO   = 5'd12;
  localparam logic [4:0] S_INT_WAIT = 5'd13;
  localparam logic [4:0] S_INT_VER  = 5'd14;
  localparam logic [4:0] S_OUT_RD   = 5'd15;
  localparam logic [4:0] S_OUT_EM   = 5'd16;

  logic [4:0] state_q, state_d;

  assign busy_o = state_q != S_IDLE;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load_vtx = 1'b1;
          if (sts_i.loaded_two) begin
            state_d = S_PLANE;
          end
        end
      end
      S_PLANE: begin
        if (sts_i.plane_done) begin
          cmd_o.out_clr = 1'b1;
          state_d = S_OUT_RD;
        end else if (!sts_i.apply) begin
          cmd_o.plane_next = 1'b1;
        end else begin
          cmd_o.rd_last = 1'b1;
          state_d = S_LD_A;
        end
      end
      S_LD_A: begin
        cmd_o.ld_a = 1'b1;
        state_d = S_RD_B;
      end
      S_RD_B: begin
        cmd_o.rd_idx = 1'b1;
        state_d = S_LD_B;
      end
      S_LD_B: begin
        cmd_o.ld_b = 1'b1;
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts_i.need_int) begin
          state_d = S_INT_CHK;
        end else begin
          cmd_o.push_a = sts_i.push_a_req;
          state_d = sts_i.push_b_req ? S_PUSH_B : S_ADV;
        end
      end
      S_PUSH_B: begin
        cmd_o.push_b = 1'b1;
        state_d = S_ADV;
      end
      S_ADV: begin
        cmd_o.adv = 1'b1;
        state_d = sts_i.i_last ? S_PASS_END : S_RD_B;
      end
      S_PASS_END: begin
        cmd_o.pass_end = 1'b1;
        state_d = sts_i.cnt_zero ? S_EMPTY : S_PLANE;
      end
      S_EMPTY: begin
        cmd_o.emit_empty = 1'b1;
        state_d = S_IDLE;
      end
      S_ERR: begin
        cmd_o.emit_err = 1'b1;
        state_d = S_IDLE;
      end
      S_INT_CHK: begin
        cmd_o.k_clr = 1'b1;
        state_d = sts_i.int_ok ? S_INT_GO : S_ERR;
      end
      S_INT_GO: begin
        cmd_o.md_start = 1'b1;
        state_d = S_INT_WAIT;
      end
      S_INT_WAIT: begin
        if (sts_i.md_done) begin
          cmd_o.pt_store = 1'b1;
          state_d = sts_i.k_last ? S_INT_VER : S_INT_GO;
        end
      end
      S_INT_VER: begin
        if (sts_i.pt_on) begin
          cmd_o.push_pt = 1'b1;
          state_d = sts_i.push_b_req ? S_PUSH_B : S_ADV;
        end else begin
          state_d = S_ERR;
        end
      end
      S_OUT_RD: begin
        cmd_o.rd_idx = 1'b1;
        state_d = S_OUT_EM;
      end
      S_OUT_EM: begin
        cmd_o.emit_vtx = 1'b1;
        cmd_o.out_next = 1'b1;
        state_d = sts_i.i_last ? S_IDLE : S_OUT_RD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `TBC_ASSERT_STD(a_busy_from_start, $rose(busy_o) |-> $past(start_i), "busy without start")
  `TBC_ASSERT_STD(a_flag_ends, (cmd_o.emit_err || cmd_o.emit_empty) |=> !busy_o, "flag not final")
  `TBC_ASSERT_STD(a_one_push, $countones({cmd_o.push_a, cmd_o.push_b, cmd_o.push_pt}) <= 1, "two pushes")

endmodule
`default_nettype wire
